/* rtl/iir_pkg.sv */
// Shared types and constants for the recursive filter core.
// Holds the beat structs, operation codes and digit-serial MAC widths.
// No dependencies.
package iir_pkg;

   // field widths fixed by the interface
   localparam int SAMPLE_W = 16;
   localparam int COEF_W   = 32;
   localparam int OP_W     = 2;
   localparam int CIDX_W   = 4;
   localparam int POLE_W   = 4;

   // digit-serial multiplier: one sample digit per cycle, msb digit first
   localparam int DIGIT_W = 4;
   localparam int NDIG    = (SAMPLE_W + DIGIT_W - 1) / DIGIT_W;
   localparam int OPND_W  = NDIG * DIGIT_W;
   localparam int PROD_W  = COEF_W + OPND_W;

   // operation codes
   localparam logic [OP_W-1:0] OP_FILTER = 2'd0;
   localparam logic [OP_W-1:0] OP_WR_FF  = 2'd1;
   localparam logic [OP_W-1:0] OP_WR_FB  = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]            op;
      logic [CIDX_W-1:0]          coef_index;
      logic signed [COEF_W-1:0]   coef_value;
      logic signed [SAMPLE_W-1:0] sample;
   } iir_req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] filtered;
      logic                       clipped;
   } iir_rsp_type;

   // sequencer to mac controls
   typedef struct packed {
      logic load;
      logic clear;
   } iir_mac_ctl_type;

   // mac to sequencer status
   typedef struct packed {
      logic digit_last;
      logic settled;
   } iir_mac_stat_type;

endpackage

/* rtl/iir_dsmac.sv */
// Digit-serial multiply-accumulate unit of the recursive filter core.
// Multiplies a coefficient by a sample one digit per cycle and sums products.
// Depends on iir_pkg.
module iir_dsmac #(
   parameter int ACC_W = 53
) (
   input  logic                              clock,
   input  logic                              reset,
   input  iir_pkg::iir_mac_ctl_type          mac_ctl,
   input  logic signed [iir_pkg::COEF_W-1:0] coef,
   input  logic signed [iir_pkg::OPND_W-1:0] opnd,
   output iir_pkg::iir_mac_stat_type         mac_stat,
   output logic signed [ACC_W-1:0]           acc
);
   import iir_pkg::*;

   localparam int DCNT_W = (NDIG > 1) ? $clog2(NDIG) : 1;

   logic signed [COEF_W-1:0]   coef_ff, coef_in;
   logic signed [OPND_W-1:0]   opnd_ff, opnd_in;
   logic [DCNT_W-1:0]          dig_ff, dig_in;
   logic                       run_ff, run_in;
   logic signed [PROD_W-1:0]   part_ff, part_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic                       prod_vld_ff, prod_vld_in;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic [DIGIT_W-1:0]         top_digit;
   logic signed [DIGIT_W:0]    digit_s;
   logic signed [COEF_W+DIGIT_W:0] step;
   logic signed [PROD_W-1:0]   part_next;
   logic                       last_dig;

   // current digit: the leading one carries the sign
   assign top_digit = opnd_ff[OPND_W-1 -: DIGIT_W];
   assign digit_s   = (dig_ff == '0) ? {top_digit[DIGIT_W-1], top_digit}
                                     : {1'b0, top_digit};
   assign step      = coef_ff * digit_s;
   // horner step: shift the partial product up one digit and add
   assign part_next = (part_ff <<< DIGIT_W) + PROD_W'(step);
   assign last_dig  = run_ff && (dig_ff == DCNT_W'(NDIG - 1));

   // operand load and digit stepping
   always_comb begin
      coef_in = coef_ff;
      opnd_in = opnd_ff;
      part_in = part_ff;
      dig_in  = dig_ff;
      run_in  = run_ff;
      if (mac_ctl.load) begin
         coef_in = coef;
         opnd_in = opnd;
         part_in = '0;
         dig_in  = '0;
         run_in  = 1'b1;
      end else if (run_ff) begin
         opnd_in = opnd_ff << DIGIT_W;
         part_in = part_next;
         dig_in  = dig_ff + 1'b1;
         run_in  = !last_dig;
      end
   end

   // finished product is registered, then summed
   always_comb begin
      prod_vld_in = last_dig;
      prod_in     = last_dig ? part_next : prod_ff;
      acc_in      = acc_ff;
      if (mac_ctl.clear) begin
         acc_in = '0;
      end else if (prod_vld_ff) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff      <= 1'b0;
         dig_ff      <= '0;
         prod_vld_ff <= 1'b0;
      end else begin
         run_ff      <= run_in;
         dig_ff      <= dig_in;
         prod_vld_ff <= prod_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      coef_ff <= coef_in;
      opnd_ff <= opnd_in;
      part_ff <= part_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign mac_stat.digit_last = last_dig;
   assign mac_stat.settled    = !run_ff && !prod_vld_ff;
   assign acc                 = acc_ff;

endmodule

/* rtl/recursive_iir_filter_core.sv */
// Top level of the direct-form-I recursive filter core.
// Holds the coefficient tables, sample history ring and tap sequencer.
// Depends on iir_pkg and iir_dsmac.
//
// A sample beat is taken only in the idle state, and the core takes no new
// beat until it has passed the multiply, drain and rounding states. The pace
// is set by the single digit-serial multiply-accumulate unit: every
// term (current input, then one past input and one past output per pole)
// goes through it at four sample bits per cycle, followed by a drain into
// the accumulator and a rounding step. Coefficient writes are taken in
// idle and give no result. A finished result waits in the output
// register, so the next beat is taken while it is still unread; a new result
// is only held back while the previous one is still unread.
module recursive_iir_filter_core #(
   parameter int MAX_POLES      = 8,
   parameter int COEF_FRAC_BITS = 28
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  iir_pkg::iir_req_type          req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output iir_pkg::iir_rsp_type          rsp_data,
   input  logic                          csr_write_en,
   input  logic [iir_pkg::POLE_W-1:0]    csr_write_data
);
   import iir_pkg::*;

   localparam int IDX_W = $clog2(MAX_POLES + 1);
   localparam int TAP_W = $clog2(2 * MAX_POLES + 1);
   localparam int ACC_W = PROD_W + TAP_W;
   localparam int QW    = ACC_W - COEF_FRAC_BITS;

   localparam logic signed [QW-1:0] SAT_HI = QW'((2 ** (SAMPLE_W - 1)) - 1);
   localparam logic signed [QW-1:0] SAT_LO = ~SAT_HI;
   localparam logic signed [SAMPLE_W-1:0] OUT_HI = SAT_HI[SAMPLE_W-1:0];
   localparam logic signed [SAMPLE_W-1:0] OUT_LO = SAT_LO[SAMPLE_W-1:0];
   localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) << (COEF_FRAC_BITS - 1);
   localparam logic [POLE_W-1:0] POLE_RESET = 4'd2;

   // sequencer states
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_MAC   = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_ROUND = 2'd3;

   logic [1:0]                 state_ff, state_in;
   logic [POLE_W-1:0]          pole_ff, pole_in;
   logic [TAP_W-1:0]           tap_ff, tap_in;
   logic [IDX_W-1:0]           rp_ff, rp_in;
   logic [IDX_W-1:0]           ring_pos_ff, ring_pos_in;
   logic signed [SAMPLE_W-1:0] x_ff, x_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   iir_rsp_type                rsp_ff, rsp_in;

   logic signed [COEF_W-1:0]   ff_coef_ff [0:MAX_POLES];
   logic signed [COEF_W-1:0]   fb_coef_ff [0:MAX_POLES];
   logic signed [SAMPLE_W-1:0] x_hist_ff  [0:MAX_POLES];
   logic signed [SAMPLE_W-1:0] y_hist_ff  [0:MAX_POLES];

   logic                       ff_we, fb_we, hist_we;
   logic [IDX_W-1:0]           coef_widx;
   logic                       idx_ok;
   logic [IDX_W-1:0]           order;
   logic [IDX_W-1:0]           p0;
   logic [TAP_W-1:0]           last_tap;
   logic [TAP_W-1:0]           next_tap;
   logic [IDX_W-1:0]           next_k;
   logic [IDX_W-1:0]           rp_step;
   logic                       commit;

   iir_mac_ctl_type            mac_ctl;
   iir_mac_stat_type           mac_stat;
   logic signed [COEF_W-1:0]   mac_coef;
   logic signed [OPND_W-1:0]   mac_opnd;
   logic signed [ACC_W-1:0]    acc;

   logic signed [ACC_W-1:0]    rnd;
   logic signed [ACC_W-1:0]    rnd_shift;
   logic signed [QW-1:0]       q;
   logic                       clip_hi, clip_lo;

   // order in use, clamped to the table depth
   assign order = ({1'b0, pole_ff} > (POLE_W + 1)'(MAX_POLES)) ? IDX_W'(MAX_POLES)
                                                              : IDX_W'(pole_ff);
   // stale ring position after an order change restarts at slot zero
   assign p0       = (ring_pos_ff > order) ? '0 : ring_pos_ff;
   assign last_tap = TAP_W'(order) << 1;
   assign next_tap = tap_ff + 1'b1;
   assign next_k   = IDX_W'((next_tap + 1'b1) >> 1);
   assign rp_step  = (rp_ff == order) ? '0 : rp_ff + 1'b1;

   assign idx_ok    = (int'(req_data.coef_index) <= MAX_POLES);
   assign coef_widx = IDX_W'(req_data.coef_index);

   assign req_ready = (state_ff == ST_IDLE);
   assign commit    = (state_ff == ST_ROUND) && (!rsp_valid_ff || rsp_ready);

   // round half up and saturate
   assign rnd       = acc + RND_HALF;
   assign rnd_shift = rnd >>> COEF_FRAC_BITS;
   assign q         = rnd_shift[QW-1:0];
   assign clip_hi   = (q > SAT_HI);
   assign clip_lo   = (q < SAT_LO);

   // tap sequencer
   always_comb begin
      state_in    = state_ff;
      tap_in      = tap_ff;
      rp_in       = rp_ff;
      x_in        = x_ff;
      ring_pos_in = ring_pos_ff;
      mac_ctl     = '0;
      mac_coef    = ff_coef_ff[0];
      mac_opnd    = OPND_W'(req_data.sample);
      ff_we       = 1'b0;
      fb_we       = 1'b0;
      hist_we     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_data.op)
                  OP_FILTER: begin
                     mac_ctl.load  = 1'b1;
                     mac_ctl.clear = 1'b1;
                     tap_in        = '0;
                     rp_in         = p0;
                     x_in          = req_data.sample;
                     state_in      = ST_MAC;
                  end
                  OP_WR_FF: ff_we = idx_ok;
                  OP_WR_FB: fb_we = idx_ok;
                  default: ;
               endcase
            end
         end
         ST_MAC: begin
            if (mac_stat.digit_last) begin
               if (tap_ff == last_tap) begin
                  state_in = ST_DRAIN;
               end else begin
                  tap_in       = next_tap;
                  mac_ctl.load = 1'b1;
                  if (next_tap[0]) begin
                     mac_coef = ff_coef_ff[next_k];
                     mac_opnd = OPND_W'(x_hist_ff[rp_ff]);
                  end else begin
                     mac_coef = fb_coef_ff[next_k];
                     mac_opnd = OPND_W'(y_hist_ff[rp_ff]);
                     rp_in    = rp_step;
                  end
               end
            end
         end
         ST_DRAIN: begin
            if (mac_stat.settled) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            if (commit) begin
               hist_we     = 1'b1;
               ring_pos_in = rp_ff;
               state_in    = ST_IDLE;
            end
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      if (commit) begin
         rsp_valid_in    = 1'b1;
         rsp_in.clipped  = clip_hi || clip_lo;
         priority if (clip_hi) begin
            rsp_in.filtered = OUT_HI;
         end else if (clip_lo) begin
            rsp_in.filtered = OUT_LO;
         end else begin
            rsp_in.filtered = q[SAMPLE_W-1:0];
         end
      end
   end

   assign pole_in = csr_write_en ? csr_write_data : pole_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pole_ff      <= POLE_RESET;
         ring_pos_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         tap_ff       <= '0;
         rp_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         pole_ff      <= pole_in;
         ring_pos_ff  <= ring_pos_in;
         rsp_valid_ff <= rsp_valid_in;
         tap_ff       <= tap_in;
         rp_ff        <= rp_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      rsp_ff <= rsp_in;
   end

   // coefficient tables and history ring, cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= MAX_POLES; i++) begin
            ff_coef_ff[i] <= '0;
            fb_coef_ff[i] <= '0;
            x_hist_ff[i]  <= '0;
            y_hist_ff[i]  <= '0;
         end
      end else begin
         if (ff_we) begin
            ff_coef_ff[coef_widx] <= req_data.coef_value;
         end
         if (fb_we) begin
            fb_coef_ff[coef_widx] <= req_data.coef_value;
         end
         if (hist_we) begin
            x_hist_ff[rp_ff] <= x_ff;
            y_hist_ff[rp_ff] <= rsp_in.filtered;
         end
      end
   end

   iir_dsmac #(
      .ACC_W (ACC_W)
   ) u_mac (
      .clock    (clock),
      .reset    (reset),
      .mac_ctl  (mac_ctl),
      .coef     (mac_coef),
      .opnd     (mac_opnd),
      .mac_stat (mac_stat),
      .acc      (acc)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // mac must be quiet whenever a new beat can be taken
   a_idle_settled: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> mac_stat.settled)
      else $error("mac busy while sequencer idle");

   // a result only appears out of the rounding state
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_ROUND)
      else $error("result raised outside rounding state");

   // tap counter and ring pointer stay inside the order in use
   a_tap_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MAC |-> (tap_ff <= last_tap) && (rp_ff <= order))
      else $error("tap or ring pointer out of range");

   // a clipped result sits on one of the rails
   a_clip_rail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.clipped |->
         (rsp_ff.filtered == OUT_HI) || (rsp_ff.filtered == OUT_LO))
      else $error("clipped result not at a rail");

endmodule

/* tb/recursive_iir_filter_core_tb.sv */
// Self-checking testbench for recursive_iir_filter_core: directed table, then random phases.
// Holds a bit-exact filter predictor, a scoreboard and the idle and stall drivers.
// Depends on iir_pkg and the recursive_iir_filter_core rtl.
module recursive_iir_filter_core_tb;
   import iir_pkg::*;

   localparam int MAX_TAP     = 8;
   localparam int FRAC        = 28;
   localparam longint SAT_HI  = 32767;
   localparam longint SAT_LO  = -32768;
   localparam logic [OP_W-1:0] OP_NONE = 2'd3;
   localparam int SETTLE      = 100;
   localparam int DRAIN_LIMIT = 200000;
   localparam int HOLD_CYCLES = 400;
   localparam int PHASES      = 12;
   localparam int PHASE_ITEMS = 146;
   localparam int PRESSURE_PH = 4;

   typedef struct {
      iir_req_type beat;
      bit          typed;
      iir_rsp_type want;
   } dir_row_type;

   logic                clock;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   iir_req_type         req_data = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   iir_rsp_type         rsp_data;
   logic                csr_write_en = 1'b0;
   logic [POLE_W-1:0]   csr_write_data = '0;

   // typed expectation travels with the beat it belongs to
   bit                  note_typed = 1'b0;
   iir_rsp_type         note_want = '0;

   // predictor state
   logic signed [COEF_W-1:0]   ff_tab [0:MAX_TAP];
   logic signed [COEF_W-1:0]   fb_tab [0:MAX_TAP];
   logic signed [SAMPLE_W-1:0] x_hist [0:MAX_TAP];
   logic signed [SAMPLE_W-1:0] y_hist [0:MAX_TAP];
   int                         ring_at;
   logic [POLE_W-1:0]          poles_cfg;

   iir_rsp_type pending_out [$];
   dir_row_type dir_tab [$];
   int          plan_poles [PHASES];

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int holds_asked    = 0;
   int holds_given    = 0;
   int hold_left      = 0;
   int mismatches     = 0;
   int beats_taken    = 0;
   int results_seen   = 0;

   recursive_iir_filter_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("FAIL");
      $finish;
   end

   function automatic void clear_filter();
      for (int i = 0; i <= MAX_TAP; i++) begin
         ff_tab[i] = '0;
         fb_tab[i] = '0;
         x_hist[i] = '0;
         y_hist[i] = '0;
      end
      ring_at   = 0;
      poles_cfg = 4'd2;
   endfunction

   // one beat through the filter model; returns 1 when it yields a result
   function automatic bit filter_beat(input iir_req_type b, output iir_rsp_type r);
      int     order;
      int     len;
      int     p;
      longint acc;
      longint q;
      r = '0;
      if (b.op == OP_WR_FF || b.op == OP_WR_FB) begin
         if (b.coef_index <= MAX_TAP) begin
            if (b.op == OP_WR_FF) ff_tab[b.coef_index] = b.coef_value;
            else fb_tab[b.coef_index] = b.coef_value;
         end
         return 1'b0;
      end
      if (b.op != OP_FILTER) return 1'b0;
      order = (poles_cfg > MAX_TAP) ? MAX_TAP : int'(poles_cfg);
      len   = order + 1;
      p     = ring_at;
      // ring position left over from a larger order restarts at slot zero
      if (p > order) p = 0;
      acc = longint'($signed(b.sample)) * longint'(ff_tab[0]);
      for (int k = 1; k <= order; k++) begin
         acc += longint'(ff_tab[k]) * longint'(x_hist[p]);
         acc += longint'(fb_tab[k]) * longint'(y_hist[p]);
         p++;
         if (p >= len) p = 0;
      end
      // round half up, then floor
      q = (acc + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
      if (q > SAT_HI) begin
         q = SAT_HI;
         r.clipped = 1'b1;
      end else if (q < SAT_LO) begin
         q = SAT_LO;
         r.clipped = 1'b1;
      end
      r.filtered = q[SAMPLE_W-1:0];
      ring_at   = p;
      x_hist[p] = b.sample;
      y_hist[p] = q[SAMPLE_W-1:0];
      return 1'b1;
   endfunction

   // scoreboard: check the result beat first, then predict the request beat
   always @(posedge clock) begin : scoreboard
      iir_rsp_type want;
      iir_rsp_type got;
      if (reset) begin
         clear_filter();
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (pending_out.size() == 0) begin
               mismatches++;
               $display("%0t: result beat with nothing expected, got %0d/%0d", $time,
                        $signed(rsp_data.filtered), rsp_data.clipped);
            end else begin
               want = pending_out.pop_front();
               if (rsp_data.filtered !== want.filtered) begin
                  mismatches++;
                  $display("%0t: filtered expected %0d, got %0d", $time,
                           $signed(want.filtered), $signed(rsp_data.filtered));
               end
               if (rsp_data.clipped !== want.clipped) begin
                  mismatches++;
                  $display("%0t: clipped expected %0d, got %0d", $time,
                           want.clipped, rsp_data.clipped);
               end
            end
         end
         if (csr_write_en) poles_cfg = csr_write_data;
         if (req_valid && req_ready) begin
            beats_taken++;
            if (filter_beat(req_data, got)) pending_out.push_back(note_typed ? note_want : got);
         end
      end
   end

   // result side: random stalls plus an occasional long hold-off
   always @(posedge clock) begin : rsp_side
      if (holds_given != holds_asked) begin
         holds_given = holds_asked;
         hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic drive_beat(input iir_req_type b, input bit typed, input iir_rsp_type want);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_data   <= b;
      note_typed <= typed;
      note_want  <= want;
      do @(posedge clock); while (!req_ready);
   endtask

   // wait for every expected result, then let the core go quiet
   task automatic settle_out();
      int n;
      n = 0;
      while (pending_out.size() != 0 && n < DRAIN_LIMIT) begin
         @(posedge clock);
         n++;
      end
      if (pending_out.size() != 0) begin
         mismatches += pending_out.size();
         $display("%0t: %0d expected results never arrived", $time, pending_out.size());
         pending_out.delete();
      end
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_poles(input logic [POLE_W-1:0] v);
      csr_write_en   <= 1'b1;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      @(posedge clock);
   endtask

   function automatic void add_row(input logic [OP_W-1:0] op, input logic [CIDX_W-1:0] idx,
                                   input logic [COEF_W-1:0] val, input logic [SAMPLE_W-1:0] smp,
                                   input bit typed, input logic [SAMPLE_W-1:0] f, input bit c);
      dir_row_type row;
      row.beat.op         = op;
      row.beat.coef_index = idx;
      row.beat.coef_value = val;
      row.beat.sample     = smp;
      row.typed           = typed;
      row.want.filtered   = f;
      row.want.clipped    = c;
      dir_tab.push_back(row);
   endfunction

   function automatic logic [COEF_W-1:0] pick_coef();
      case ($urandom_range(9))
         0: return $urandom;
         1: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         2: return '0;
         3, 4: return COEF_W'(int'($urandom_range(1 << 27)) - (1 << 26));
         default: return COEF_W'(int'($urandom_range(1 << 25)) - (1 << 24));
      endcase
   endfunction

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(5))
         0: return $urandom_range(1) ? 16'h7FFF : 16'h8000;
         1, 2: return SAMPLE_W'(int'($urandom_range(2000)) - 1000);
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   function automatic iir_req_type rand_beat();
      iir_req_type b;
      int          r;
      r    = $urandom_range(99);
      b.op = (r < 62) ? OP_FILTER : (r < 80) ? OP_WR_FF : (r < 96) ? OP_WR_FB : OP_NONE;
      b.coef_index = ($urandom_range(99) < 85) ? CIDX_W'($urandom_range(MAX_TAP))
                                               : CIDX_W'($urandom_range(15, 9));
      b.coef_value = pick_coef();
      b.sample     = pick_sample();
      return b;
   endfunction

   function automatic bit has_effect(input iir_req_type b);
      return b.op == OP_FILTER ||
             ((b.op == OP_WR_FF || b.op == OP_WR_FB) && b.coef_index <= MAX_TAP);
   endfunction

   initial begin : stimulus
      iir_req_type b;
      int          done;
      int          mode;
      plan_poles = '{8, 0, 15, 1, 8, 3, 9, 2, 0, 5, 8, 1};

      // directed rows at the reset order of two
      add_row(OP_FILTER, 0, '0, 16'h7FFF, 1, 16'h0000, 0);
      add_row(OP_FILTER, 0, '0, 16'h8000, 1, 16'h0000, 0);
      add_row(OP_NONE, 4'hF, 32'hFFFF_FFFF, 16'hFFFF, 0, '0, 0);
      add_row(OP_WR_FF, 0, 32'h7FFF_FFFF, '0, 0, '0, 0);
      add_row(OP_FILTER, 0, '0, 16'h7FFF, 1, 16'h7FFF, 1);
      add_row(OP_FILTER, 0, '0, 16'h8000, 1, 16'h8000, 1);
      add_row(OP_WR_FF, 0, 32'h8000_0000, '0, 0, '0, 0);
      add_row(OP_FILTER, 0, '0, 16'h8000, 1, 16'h7FFF, 1);
      add_row(OP_FILTER, 0, '0, 16'h7FFF, 1, 16'h8000, 1);
      // tap index past the table is dropped
      add_row(OP_WR_FF, 4'd9, 32'h1000_0000, '0, 0, '0, 0);
      add_row(OP_WR_FB, 4'hF, 32'h7FFF_FFFF, '0, 0, '0, 0);
      add_row(OP_WR_FF, 0, 32'h1000_0000, '0, 0, '0, 0);
      add_row(OP_FILTER, 0, '0, 16'd4660, 1, 16'd4660, 0);
      // half gain: rounding of plus and minus one half
      add_row(OP_WR_FF, 0, 32'h0800_0000, '0, 0, '0, 0);
      add_row(OP_FILTER, 0, '0, 16'h0001, 0, '0, 0);
      add_row(OP_FILTER, 0, '0, 16'hFFFF, 0, '0, 0);
      // feedback tap zero is stored but never weighted
      add_row(OP_WR_FB, 0, 32'h7FFF_FFFF, '0, 0, '0, 0);
      add_row(OP_FILTER, 0, '0, 16'd100, 0, '0, 0);
      add_row(OP_WR_FF, 4'd1, 32'h1000_0000, '0, 0, '0, 0);
      add_row(OP_WR_FB, 4'd1, 32'hF800_0000, '0, 0, '0, 0);
      add_row(OP_WR_FF, 4'd2, 32'hF000_0000, '0, 0, '0, 0);
      add_row(OP_WR_FB, 4'd2, 32'h0400_0000, '0, 0, '0, 0);
      add_row(OP_WR_FF, 4'd8, 32'h7FFF_FFFF, '0, 0, '0, 0);
      add_row(OP_FILTER, 0, '0, 16'd20000, 0, '0, 0);
      add_row(OP_FILTER, 0, '0, -16'sd20000, 0, '0, 0);
      add_row(OP_FILTER, 0, '0, 16'h7FFF, 0, '0, 0);

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_tab[i]) drive_beat(dir_tab[i].beat, dir_tab[i].typed, dir_tab[i].want);
      req_valid <= 1'b0;
      settle_out();

      // random phases: new order each time, idle pattern rotating
      for (int ph = 0; ph < PHASES; ph++) begin
         write_poles(POLE_W'(plan_poles[ph]));
         mode = ph % 4;
         send_idle_pct  = (mode == 1) ? 86 : (mode == 3) ? 7 : 0;
         recv_stall_pct = (mode == 2) ? 86 : (mode == 3) ? 7 : 0;
         if (ph == PRESSURE_PH) holds_asked++;
         done = 0;
         while (done < PHASE_ITEMS) begin
            b = rand_beat();
            drive_beat(b, 1'b0, '0);
            if (has_effect(b)) done++;
         end
         req_valid <= 1'b0;
         settle_out();
      end

      $display("run covered %0d request beats and %0d filtered results over %0d orders,",
               beats_taken, results_seen, PHASES + 1);
      $display("with idle sender, stalled receiver and a long output hold-off");
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
